// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersect package
// Shared widths, register indexes and the sideband type of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  localparam int unsigned CW  = 32;  // coordinate and distance width
  localparam int unsigned NAX = 3;   // number of axes
  localparam int unsigned IW  = 3;   // configuration index width

  localparam logic [IW-1:0] REG_MIN_X = 3'd0;
  localparam logic [IW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IW-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IW-1:0] REG_MAX_X = 3'd3;
  localparam logic [IW-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IW-1:0] REG_MAX_Z = 3'd5;
  localparam logic [IW-1:0] REG_EMPTY = 3'd6;

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  // Per-item information that travels beside the dividers.
  typedef struct packed {
    logic [NAX-1:0] neg_lo;    // quotient toward the lower plane is negative
    logic [NAX-1:0] neg_hi;    // quotient toward the upper plane is negative
    logic [NAX-1:0] parallel;  // zero direction on this axis
    logic           reject;
  } rbsi_side_t;

endpackage

`default_nettype wire

// ===== rtl/rbsi_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring long division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_divider #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  // The numerator bits shift out at the top while quotient bits shift in.
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_rest
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      nq_q[k]  <= {nq_in[NW-2:0], ge};
      rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

`default_nettype wire

// ===== rtl/ray_box_slab_intersect_core.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection core
// Fixed-point slab test of one ray against a configured axis-aligned box.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle; busy never rises, since every stage moves
// on each cycle and the receiver cannot stall. The pipeline depth is set by
// the six pipelined dividers, which resolve one quotient bit per stage.
// Reset clears the valid bits and loads the box registers with an empty box.
`default_nettype none

module ray_box_slab_intersect_core
  import rbsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [IW-1:0]        cfg_index_i,
  input  wire logic [CW-1:0]        cfg_data_i,
  // Request side.
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [CW-1:0] origin_x_i,
  input  wire logic signed [CW-1:0] origin_y_i,
  input  wire logic signed [CW-1:0] origin_z_i,
  input  wire logic signed [CW-1:0] dir_x_i,
  input  wire logic signed [CW-1:0] dir_y_i,
  input  wire logic signed [CW-1:0] dir_z_i,
  // Result side.
  output logic                      result_valid_o,
  output logic signed [CW-1:0]      t_near_o,
  output logic signed [CW-1:0]      t_far_o,
  output logic                      early_reject_o
);

  // Numerator is |bound - origin| (33 bits) scaled by 2^FRAC_BITS.
  localparam int unsigned NW = CW + 1 + FRAC_BITS;
  localparam logic signed [CW-1:0] T_REJECT = CW'(10) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must write them only while no ray is
  // in flight; the block has no check for it. The first stage reads them directly.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] box_lo_q [NAX];
  logic signed [CW-1:0] box_hi_q [NAX];
  logic                 box_empty_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NAX; a++) begin
        box_lo_q[a] <= '0;
        box_hi_q[a] <= '0;
      end
      box_empty_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_X: box_lo_q[0] <= cfg_data_i;
        REG_MIN_Y: box_lo_q[1] <= cfg_data_i;
        REG_MIN_Z: box_lo_q[2] <= cfg_data_i;
        REG_MAX_X: box_hi_q[0] <= cfg_data_i;
        REG_MAX_Y: box_hi_q[1] <= cfg_data_i;
        REG_MAX_Z: box_hi_q[2] <= cfg_data_i;
        REG_EMPTY: box_empty_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: plane differences, magnitudes and signs, parallel-axis checks.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] org   [NAX];
  logic signed [CW-1:0] dir   [NAX];
  logic        [NW-1:0] num_lo_d [NAX];
  logic        [NW-1:0] num_hi_d [NAX];
  logic        [CW-1:0] den_d    [NAX];
  logic        [NW-1:0] num_lo_q [NAX];
  logic        [NW-1:0] num_hi_q [NAX];
  logic        [CW-1:0] den_q    [NAX];
  rbsi_side_t           side_a_d, side_a_q;
  logic                 vld_a_q;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    logic signed [CW:0] diff_lo;
    logic signed [CW:0] diff_hi;
    logic        [CW:0] mag_lo;
    logic        [CW:0] mag_hi;
    logic               zero_dir;
    logic               outside;
    side_a_d        = '0;
    side_a_d.reject = box_empty_q;
    for (int a = 0; a < NAX; a++) begin
      diff_lo  = {box_lo_q[a][CW-1], box_lo_q[a]} - {org[a][CW-1], org[a]};
      diff_hi  = {box_hi_q[a][CW-1], box_hi_q[a]} - {org[a][CW-1], org[a]};
      mag_lo   = diff_lo[CW] ? (CW+1)'(-diff_lo) : diff_lo;
      mag_hi   = diff_hi[CW] ? (CW+1)'(-diff_hi) : diff_hi;
      zero_dir = (dir[a] == '0);
      outside  = (org[a] < box_lo_q[a]) || (org[a] > box_hi_q[a]);
      num_lo_d[a] = {mag_lo, {FRAC_BITS{1'b0}}};
      num_hi_d[a] = {mag_hi, {FRAC_BITS{1'b0}}};
      den_d[a]    = dir[a][CW-1] ? CW'(-dir[a]) : dir[a];
      side_a_d.neg_lo[a]   = diff_lo[CW] ^ dir[a][CW-1];
      side_a_d.neg_hi[a]   = diff_hi[CW] ^ dir[a][CW-1];
      side_a_d.parallel[a] = zero_dir;
      if (zero_dir && outside) begin
        side_a_d.reject = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NAX; a++) begin
      num_lo_q[a] <= num_lo_d[a];
      num_hi_q[a] <= num_hi_d[a];
      den_q[a]    <= den_d[a];
    end
    side_a_q <= side_a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= start;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: six magnitude quotients. The sideband and the valid bit follow
  // through a delay line as long as the divider pipeline.
  // --------------------------------------------------------------------------
  logic [NW-1:0] quo_lo [NAX];
  logic [NW-1:0] quo_hi [NAX];

  for (genvar a = 0; a < NAX; a++) begin : g_axis
    rbsi_divider #(.NW(NW), .DW(CW)) u_div_lo (
      .clk_i (clk_i),
      .num_i (num_lo_q[a]),
      .den_i (den_q[a]),
      .quo_o (quo_lo[a])
    );
    rbsi_divider #(.NW(NW), .DW(CW)) u_div_hi (
      .clk_i (clk_i),
      .num_i (num_hi_q[a]),
      .den_i (den_q[a]),
      .quo_o (quo_hi[a])
    );
  end

  rbsi_side_t    side_dly_q [NW];
  logic [NW-1:0] vld_dly_q;

  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= side_a_q;
    for (int k = 1; k < NW; k++) begin
      side_dly_q[k] <= side_dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dly_q <= '0;
    end else begin
      vld_dly_q <= {vld_dly_q[NW-2:0], vld_a_q};
    end
  end

  // --------------------------------------------------------------------------
  // Stage F1: apply the sign and saturate each plane distance. A parallel
  // axis that did not reject becomes the unbounded interval.
  // --------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] sat_signed(input logic [NW-1:0] mag,
                                                      input logic neg);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = |mag[NW-1:CW-1];
    neg_ovf = (|mag[NW-1:CW]) || (mag[CW-1] && (|mag[CW-2:0]));
    if (neg) begin
      sat_signed = neg_ovf ? T_MIN : CW'(-mag[CW-1:0]);
    end else begin
      sat_signed = pos_ovf ? T_MAX : mag[CW-1:0];
    end
  endfunction

  logic signed [CW-1:0] p_lo_d [NAX];
  logic signed [CW-1:0] p_hi_d [NAX];
  logic signed [CW-1:0] p_lo_q [NAX];
  logic signed [CW-1:0] p_hi_q [NAX];
  logic                 rej_f1_q, vld_f1_q;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      if (side_dly_q[NW-1].parallel[a]) begin
        p_lo_d[a] = T_MIN;
        p_hi_d[a] = T_MAX;
      end else begin
        p_lo_d[a] = sat_signed(quo_lo[a], side_dly_q[NW-1].neg_lo[a]);
        p_hi_d[a] = sat_signed(quo_hi[a], side_dly_q[NW-1].neg_hi[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NAX; a++) begin
      p_lo_q[a] <= p_lo_d[a];
      p_hi_q[a] <= p_hi_d[a];
    end
    rej_f1_q <= side_dly_q[NW-1].reject;
  end

  // --------------------------------------------------------------------------
  // Stage F2: order each axis pair into near and far.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] near_q [NAX];
  logic signed [CW-1:0] far_q  [NAX];
  logic                 rej_f2_q, vld_f2_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NAX; a++) begin
      if (p_lo_q[a] > p_hi_q[a]) begin
        near_q[a] <= p_hi_q[a];
        far_q[a]  <= p_lo_q[a];
      end else begin
        near_q[a] <= p_lo_q[a];
        far_q[a]  <= p_hi_q[a];
      end
    end
    rej_f2_q <= rej_f1_q;
  end

  // --------------------------------------------------------------------------
  // Stage F3: entry is the largest near, exit the smallest far; a rejected
  // ray gets the sentinel pair.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] t_near_d, t_far_d;

  always_comb begin
    t_near_d = near_q[0];
    t_far_d  = far_q[0];
    for (int a = 1; a < NAX; a++) begin
      if (near_q[a] > t_near_d) begin
        t_near_d = near_q[a];
      end
      if (far_q[a] < t_far_d) begin
        t_far_d = far_q[a];
      end
    end
    if (rej_f2_q) begin
      t_near_d = T_REJECT;
      t_far_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    t_near_o       <= t_near_d;
    t_far_o        <= t_far_d;
    early_reject_o <= rej_f2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f1_q       <= 1'b0;
      vld_f2_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      vld_f1_q       <= vld_dly_q[NW-1];
      vld_f2_q       <= vld_f1_q;
      result_valid_o <= vld_f2_q;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection testbench
// Drives rays through the core under several box settings and idle patterns,
// predicts each entry/exit pair in the testbench and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbsi_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = FRAC + 37;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // One ray request.
  typedef struct packed {
    logic signed [CW-1:0] ox, oy, oz;
    logic signed [CW-1:0] dx, dy, dz;
  } ray_t;

  // One expected entry/exit pair.
  typedef struct packed {
    logic signed [CW-1:0] t_near;
    logic signed [CW-1:0] t_far;
    logic                 reject;
  } slab_hit_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic start, busy;
  ray_t cur_ray;
  logic res_valid, res_reject;
  logic signed [CW-1:0] res_near, res_far;

  ray_box_slab_intersect_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start(start), .busy(busy),
    .origin_x_i(cur_ray.ox), .origin_y_i(cur_ray.oy), .origin_z_i(cur_ray.oz),
    .dir_x_i(cur_ray.dx), .dir_y_i(cur_ray.dy), .dir_z_i(cur_ray.dz),
    .result_valid_o(res_valid), .t_near_o(res_near), .t_far_o(res_far),
    .early_reject_o(res_reject)
  );

  // Predictor copy of the box registers.
  longint box_lo[3], box_hi[3];
  bit     box_empty;

  ray_t      pending_rays[$];
  slab_hit_t expected_hits[$];
  int        error_count;
  int        sender_idle_pct;
  bit        sender_hold;
  longint unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Saturate a 64-bit value to the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Distance to one bounding plane; the numerator fits in 64 bits and SV
  // division truncates toward zero, as the hardware does.
  function automatic longint plane_t(longint bound, longint org, longint dir);
    longint num;
    num = (bound - org) * (longint'(1) <<< FRAC);
    return clamp32(num / dir);
  endfunction

  // Slab test of one ray against the predictor's box.
  function automatic slab_hit_t slab_test(ray_t r);
    longint org[3], dir[3];
    longint lo, hi, swp, tn, tf;
    bit rej;
    slab_hit_t h;
    org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
    dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
    tn = -64'sd2147483648;
    tf = 64'sd2147483647;
    rej = box_empty;
    for (int a = 0; a < 3; a++) begin
      if (rej) break;
      if (dir[a] == 0) begin
        // A parallel axis either rejects or adds no constraint.
        if (org[a] < box_lo[a] || org[a] > box_hi[a]) rej = 1'b1;
        continue;
      end
      lo = plane_t(box_lo[a], org[a], dir[a]);
      hi = plane_t(box_hi[a], org[a], dir[a]);
      if (lo > hi) begin
        swp = lo; lo = hi; hi = swp;
      end
      if (lo > tn) tn = lo;
      if (hi < tf) tf = hi;
    end
    if (rej) begin
      tn = longint'(10) <<< FRAC;
      tf = 0;
    end
    h.t_near = tn[CW-1:0];
    h.t_far  = tf[CW-1:0];
    h.reject = rej;
    return h;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: a request leaves the queue at each edge where start is high and
  // busy is low; a new one is offered at random according to the idle rate.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      cur_ray <= '0;
    end else begin
      if (start && !busy) begin
        expected_hits.push_back(slab_test(cur_ray));
        void'(pending_rays.pop_front());
      end
      if (start && busy) begin
        // Hold the current request.
      end else if (pending_rays.size() > 0 && !sender_hold &&
                   $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        cur_ray <= pending_rays[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    slab_hit_t want;
    if (rst_n && res_valid) begin
      if (expected_hits.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_hits.pop_front();
        if (res_near !== want.t_near) report_mismatch("t_near", res_near, want.t_near);
        if (res_far !== want.t_far) report_mismatch("t_far", res_far, want.t_far);
        if (res_reject !== want.reject)
          report_mismatch("early_reject", res_reject, want.reject);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Write one box register while the core is idle and mirror it.
  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_MIN_Z) box_lo[idx] = longint'($signed(val));
    else if (idx <= REG_MAX_Z) box_hi[idx - REG_MAX_X] = longint'($signed(val));
    else if (idx == REG_EMPTY) box_empty = val[0];
  endtask

  task automatic set_box(logic [CW-1:0] lx, ly, lz, hx, hy, hz, bit empty);
    write_reg(REG_MIN_X, lx); write_reg(REG_MIN_Y, ly); write_reg(REG_MIN_Z, lz);
    write_reg(REG_MAX_X, hx); write_reg(REG_MAX_Y, hy); write_reg(REG_MAX_Z, hz);
    write_reg(REG_EMPTY, {31'd0, empty});
  endtask

  // Wait until every queued request is accepted and every result is back.
  task automatic drain();
    while (pending_rays.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(bit narrow);
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom();
      default: return narrow ? $signed($urandom_range(40 << 16)) - (20 << 16) : $urandom();
    endcase
  endfunction

  // Directions favor zero so parallel slabs are hit often.
  function automatic logic [CW-1:0] rand_dir();
    case ($urandom_range(9))
      0, 1: return '0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $signed($urandom_range(3)) - 1;
      5: return $urandom();
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    bit narrow;
    narrow = ($urandom_range(3) != 0);
    r.ox = rand_coord(narrow); r.oy = rand_coord(narrow); r.oz = rand_coord(narrow);
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    return r;
  endfunction

  task automatic queue_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    pending_rays.push_back(r);
  endtask

  task automatic random_phase(int count, int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) pending_rays.push_back(rand_ray());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    sender_hold = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    box_empty = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: the box is empty, so every ray is rejected.
    queue_ray(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0);
    queue_ray(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
    drain();

    // Unit box [-1,1]^3, directed cases.
    set_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
            32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    queue_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0);            // hit along x
    queue_ray(32'h0005_0000, 0, 0, 32'hffff_0000, 0, 0);            // negative dir swap
    queue_ray(0, 32'h0005_0000, 0, 0, 32'hffff_0000, 0);            // swap on y
    queue_ray(0, 0, 32'hfffb_0000, 0, 0, 32'h0001_0000);            // z
    queue_ray(32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0);            // parallel x outside
    queue_ray(0, 32'hfffe_0000, 0, 32'h0001_0000, 0, 0);            // parallel y outside
    queue_ray(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);            // parallel inside, bound
    queue_ray(0, 0, 0, 0, 0, 0);                                    // all parallel inside
    queue_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1); // saturation
    queue_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_ray(32'h7fff_ffff, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_ray(32'h0000_8000, 32'h0003_0000, 0, 32'h0000_0003, 32'h0000_0007, 0);
    drain();

    // Extreme box with inverted x; a parallel x axis on it always rejects.
    set_box(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    queue_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    queue_ray(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    queue_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 32'hffff_ffff);
    drain();
    random_phase(150, 0);

    // Moderate box; random phases under varying sender idle rates.
    set_box(32'hfffd_0000, 32'hfff8_0000, 32'hfffe_8000,
            32'h0004_0000, 32'h0002_0000, 32'h0006_0000, 1'b0);
    random_phase(200, 49);
    random_phase(100, 0);

    // The sender holds off until the pipeline is fully drained, mid-stream.
    for (int i = 0; i < 60; i++) pending_rays.push_back(rand_ray());
    sender_idle_pct = 29;
    while (pending_rays.size() > 30) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_hits.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    drain();

    // Random box, including possibly inverted bounds.
    set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    random_phase(150, 29);
    set_box(32'hffec_0000, 32'hffec_0000, 32'hffec_0000,
            32'h0014_0000, 32'h0014_0000, 32'h0014_0000, 1'b0);
    random_phase(150, 49);

    // Back to an empty box with nonzero bounds.
    set_box(32'hffff_0000, 0, 0, 32'h0001_0000, 0, 0, 1'b1);
    random_phase(40, 0);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
